@@ rtl/rdq_pkg.sv @@
// Package with the shared sizes, operation codes and command type of the ring deque.
`timescale 1ns / 1ps

package rdq_pkg;

  // Deque depth in entries and task word width in bits.
  localparam int unsigned DEPTH     = 64;
  localparam int unsigned WORD_BITS = 32;

  // Widths of the fixed port fields.
  localparam int unsigned OP_W   = 2;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FILL_W = 7;
  localparam int unsigned OUT_W  = 48;

  // Derived storage and counter widths.
  localparam int unsigned STORE_W = (WORD_BITS < DATA_W) ? WORD_BITS : DATA_W;
  localparam int unsigned PTR_W   = $clog2(DEPTH);
  localparam int unsigned CNT_W   = $clog2(DEPTH + 1);

  // Operation codes carried on the input tuser.
  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_STEAL = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;  // capture the input transaction
    logic exec;  // perform the captured operation
  } rdq_cmd_t;

endpackage

@@ rtl/rdq_ctrl.sv @@
// Controller state machine that sequences load, execute and result delivery.
`timescale 1ns / 1ps

module rdq_ctrl import rdq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rdq_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   in_fire;

  // A new transaction is taken when idle or as the waiting result leaves.
  assign in_ready_o  = (state_q == ST_IDLE) || ((state_q == ST_OUT) && out_ready_i);
  assign out_valid_o = (state_q == ST_OUT);
  assign in_fire     = in_valid_i && in_ready_o;

  assign cmd_o.load = in_fire;
  assign cmd_o.exec = (state_q == ST_EXEC);

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = in_fire ? ST_EXEC : ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/rdq_dpath.sv @@
// Datapath with the entry memory, ring indices, fill count, run tally and result registers.
`timescale 1ns / 1ps

module rdq_dpath import rdq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rdq_cmd_t          cmd_i,
  input  logic [OP_W-1:0]   op_i,
  input  logic [DATA_W-1:0] word_i,
  input  logic              last_i,
  output logic [OUT_W-1:0]  result_o
);

  localparam logic [PTR_W-1:0] PtrMax  = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CntFull = CNT_W'(DEPTH);

  // Captured input transaction.
  op_e                op_q;
  logic [STORE_W-1:0] word_q;
  logic               last_q;

  // Deque state.
  logic [STORE_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]   front_q, front_d;
  logic [PTR_W-1:0]   back_q, back_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   tally_q, tally_d;

  // Result registers.
  logic               ok_q, ok_d;
  logic               got_q, got_d;
  logic [CNT_W-1:0]   acc_q, acc_d;
  logic [STORE_W-1:0] rd_data_q;

  logic               wr_en, rd_en;
  logic [PTR_W-1:0]   rd_addr;
  logic [PTR_W-1:0]   back_prev, back_next, front_next;
  logic [CNT_W-1:0]   tally_inc;

  assign back_next  = (back_q == PtrMax) ? '0 : back_q + PTR_W'(1);
  assign back_prev  = (back_q == '0) ? PtrMax : back_q - PTR_W'(1);
  assign front_next = (front_q == PtrMax) ? '0 : front_q + PTR_W'(1);
  assign tally_inc  = (tally_q < CntFull) ? tally_q + CNT_W'(1) : tally_q;

  // Capture the input transaction.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= op_e'(op_i);
      word_q <= word_i[STORE_W-1:0];
      last_q <= last_i;
    end
  end

  // Operation decode and state update.
  always_comb begin
    front_d = front_q;
    back_d  = back_q;
    count_d = count_q;
    tally_d = tally_q;
    ok_d    = 1'b0;
    got_d   = 1'b0;
    acc_d   = '0;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    rd_addr = front_q;
    case (op_q)
      OP_PUSH: begin
        if (count_q != CntFull) begin
          wr_en   = 1'b1;
          back_d  = back_next;
          count_d = count_q + CNT_W'(1);
          ok_d    = 1'b1;
          tally_d = tally_inc;
        end
        if (last_q) begin
          acc_d   = tally_d;
          tally_d = '0;
        end
      end
      OP_POP: begin
        if (count_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = front_q;
          front_d = front_next;
          count_d = count_q - CNT_W'(1);
          ok_d    = 1'b1;
          got_d   = 1'b1;
        end
      end
      OP_STEAL: begin
        if (count_q != '0) begin
          rd_en   = 1'b1;
          rd_addr = back_prev;
          back_d  = back_prev;
          count_d = count_q - CNT_W'(1);
          ok_d    = 1'b1;
          got_d   = 1'b1;
        end
      end
      OP_CLEAR: begin
        front_d = '0;
        back_d  = '0;
        count_d = '0;
        ok_d    = 1'b1;
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
  end

  // Entry memory with registered read data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && wr_en) mem[back_q] <= word_q;
    if (cmd_i.exec && rd_en) rd_data_q <= mem[rd_addr];
  end

  // Indices, fill count and run tally.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
      tally_q <= '0;
    end else if (cmd_i.exec) begin
      front_q <= front_d;
      back_q  <= back_d;
      count_q <= count_d;
      tally_q <= tally_d;
    end
  end

  // Result flags held until the next operation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      ok_q  <= ok_d;
      got_q <= got_d;
      acc_q <= acc_d;
    end
  end

  // Result packing: ok, payload_out, fill_count, is_empty, batch_accepted.
  assign result_o = {FILL_W'(acc_q),
                     (count_q == '0),
                     FILL_W'(count_q),
                     got_q ? DATA_W'(rd_data_q) : {DATA_W{1'b0}},
                     ok_q};

endmodule

@@ rtl/ring_deque_push_pop_steal.sv @@
// Top level of the ring-buffer deque with push, pop and steal operations.
//
//   channel     direction  fields (lowest bit first)
//   s_axis      in         tuser: op[1:0]; tdata: payload_in[31:0]; tlast: batch_end
//   m_axis      out        tdata: ok, payload_out[31:0], fill_count[6:0],
//                          is_empty, batch_accepted[6:0]
//
// The accepting edge captures the transaction; the execute state then updates the indices
// and accesses the entry memory, and the result is held in the output state until taken.
// A new transaction is accepted only while idle or as the previous result is taken.
// Reset clears the indices, the fill count and the run tally; entries are not cleared.
// A stalled result holds its value and a new transaction enters as it is taken.
`timescale 1ns / 1ps

module ring_deque_push_pop_steal import rdq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [DATA_W-1:0] s_axis_tdata,   // payload_in
  input  logic [OP_W-1:0]   s_axis_tuser,   // op
  input  logic              s_axis_tlast,   // batch_end
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [OUT_W-1:0]  m_axis_tdata    // ok, payload_out, fill_count, is_empty,
                                            // batch_accepted
);

  rdq_cmd_t cmd;

  // Sequencing of each transaction.
  rdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  // Storage, indices and result formation.
  rdq_dpath u_dpath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .op_i     (s_axis_tuser),
    .word_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .result_o (m_axis_tdata)
  );

endmodule

@@ tb/tb_ring_deque_push_pop_steal.sv @@
// Self-checking testbench for the ring deque with push, pop, steal and clear operations.
`timescale 1ns / 1ps

module tb_ring_deque_push_pop_steal;
  import rdq_pkg::*;

  // Bit positions of the result fields inside m_axis_tdata.
  localparam int unsigned OK_LSB    = 0;
  localparam int unsigned WORD_LSB  = 1;
  localparam int unsigned FILL_LSB  = WORD_LSB + DATA_W;
  localparam int unsigned EMPTY_LSB = FILL_LSB + FILL_W;
  localparam int unsigned BATCH_LSB = EMPTY_LSB + 1;

  localparam int unsigned RANDOM_OPS = 1750;
  localparam int unsigned MAX_PRINTED_ERRORS = 30;

  // One operation waiting to be driven.
  typedef struct {
    op_e               op;
    logic [DATA_W-1:0] word;
    logic              last;
    bit                drain;  // hold back until all outstanding results are back
  } deque_op_t;

  // One result transaction, field by field.
  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] word;
    logic [FILL_W-1:0] fill;
    logic              empty;
    logic [FILL_W-1:0] batch;
  } deque_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [DATA_W-1:0] s_axis_tdata = '0;  // payload_in
  logic [OP_W-1:0]   s_axis_tuser = OP_PUSH;  // op
  logic              s_axis_tlast = 1'b0;  // batch_end
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b1;
  logic [OUT_W-1:0]  m_axis_tdata;  // ok, payload_out, fill_count, is_empty, batch_accepted

  ring_deque_push_pop_steal dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #1 clk_i = ~clk_i;

  // Operations still to be driven and results still owed by the block.
  deque_op_t     op_backlog[$];
  deque_result_t awaited_results[$];

  // Shadow copy of the deque state.
  logic [STORE_W-1:0] shadow_mem [DEPTH];
  logic [PTR_W-1:0]   shadow_front = '0;
  logic [PTR_W-1:0]   shadow_back = '0;
  logic [CNT_W-1:0]   shadow_count = '0;
  logic [CNT_W-1:0]   shadow_tally = '0;

  // Run statistics.
  int unsigned err_count = 0;
  int unsigned n_results = 0;
  int unsigned n_push_taken = 0;
  int unsigned n_push_refused = 0;
  int unsigned n_pop_taken = 0;
  int unsigned n_steal_taken = 0;
  int unsigned n_take_empty = 0;
  int unsigned n_clear = 0;
  int unsigned n_runs = 0;
  int unsigned n_runs_saturated = 0;
  int unsigned n_full_hits = 0;

  // Handshake bookkeeping for the driver and the receiver.
  logic in_taken = 1'b0;
  int   gap_left = 0;
  int   burst_left = 8;
  int unsigned stall_cycle = 0;
  logic [31:0] ready_pattern = '1;

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTED_ERRORS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic logic [PTR_W-1:0] ring_next(logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // Apply one operation to the shadow deque and return the result it must produce.
  function automatic deque_result_t apply_op(op_e op, logic [DATA_W-1:0] word, logic last);
    deque_result_t r;
    logic [PTR_W-1:0] slot;
    r = '0;
    case (op)
      OP_PUSH: begin
        if (shadow_count < DEPTH) begin
          shadow_mem[shadow_back] = word[STORE_W-1:0];
          shadow_back = ring_next(shadow_back);
          shadow_count++;
          r.ok = 1'b1;
          if (shadow_tally < DEPTH) shadow_tally++;
          n_push_taken++;
          if (shadow_count == DEPTH) n_full_hits++;
        end else begin
          n_push_refused++;
        end
        // The last push of a run reports its tally and starts a new run.
        if (last) begin
          r.batch = shadow_tally;
          n_runs++;
          if (shadow_tally == DEPTH) n_runs_saturated++;
          shadow_tally = '0;
        end
      end
      OP_POP: begin
        if (shadow_count != 0) begin
          r.word = DATA_W'(shadow_mem[shadow_front]);
          shadow_front = ring_next(shadow_front);
          shadow_count--;
          r.ok = 1'b1;
          n_pop_taken++;
        end else begin
          n_take_empty++;
        end
      end
      OP_STEAL: begin
        if (shadow_count != 0) begin
          slot = (shadow_back == '0) ? PTR_W'(DEPTH - 1) : shadow_back - PTR_W'(1);
          r.word = DATA_W'(shadow_mem[slot]);
          shadow_back = slot;
          shadow_count--;
          r.ok = 1'b1;
          n_steal_taken++;
        end else begin
          n_take_empty++;
        end
      end
      default: begin
        // Clear keeps the stored words and the run tally.
        shadow_front = '0;
        shadow_back = '0;
        shadow_count = '0;
        r.ok = 1'b1;
        n_clear++;
      end
    endcase
    r.fill = FILL_W'(shadow_count);
    r.empty = (shadow_count == 0);
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic enqueue_op(input op_e op, input logic [DATA_W-1:0] word, input logic last,
                            input bit drain);
    deque_op_t it;
    it.op = op;
    it.word = word;
    it.last = last;
    it.drain = drain;
    op_backlog.push_back(it);
  endtask

  // Predict on every accepted operation; compare every accepted result.
  always @(posedge clk_i) begin : scoreboard
    deque_result_t seen;
    deque_result_t want;
    if (rst_ni) begin
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (m_axis_tvalid && m_axis_tready) begin
        n_results++;
        seen.ok = m_axis_tdata[OK_LSB];
        seen.word = m_axis_tdata[WORD_LSB +: DATA_W];
        seen.fill = m_axis_tdata[FILL_LSB +: FILL_W];
        seen.empty = m_axis_tdata[EMPTY_LSB];
        seen.batch = m_axis_tdata[BATCH_LSB +: FILL_W];
        if (awaited_results.size() == 0) begin
          flag_error($sformatf("unexpected result transaction %h", m_axis_tdata));
        end else begin
          want = awaited_results.pop_front();
          if (seen.ok !== want.ok)
            flag_error($sformatf("result %0d ok %b, want %b", n_results, seen.ok, want.ok));
          if (seen.word !== want.word)
            flag_error($sformatf("result %0d payload %h, want %h",
                                 n_results, seen.word, want.word));
          if (seen.fill !== want.fill)
            flag_error($sformatf("result %0d fill %0d, want %0d",
                                 n_results, seen.fill, want.fill));
          if (seen.empty !== want.empty)
            flag_error($sformatf("result %0d empty %b, want %b",
                                 n_results, seen.empty, want.empty));
          if (seen.batch !== want.batch)
            flag_error($sformatf("result %0d batch count %0d, want %0d",
                                 n_results, seen.batch, want.batch));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        awaited_results.push_back(apply_op(op_e'(s_axis_tuser), s_axis_tdata, s_axis_tlast));
    end
  end

  // Sender: bursts of operations separated by random gaps.
  always @(negedge clk_i) begin : op_driver
    deque_op_t it;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (op_backlog.size() != 0 &&
                   !(op_backlog[0].drain && awaited_results.size() != 0)) begin
        it = op_backlog.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= it.word;
        s_axis_tuser <= it.op;
        s_axis_tlast <= it.last;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: a stall pattern redrawn periodically as always ready, random, mostly ready or mostly stalled.
  always @(negedge clk_i) begin : result_stall
    stall_cycle++;
    if (stall_cycle % 128 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern = '1;
        1: ready_pattern = $urandom();
        2: ready_pattern = $urandom() | $urandom();
        default: ready_pattern = $urandom() & $urandom();
      endcase
    end
    m_axis_tready <= ready_pattern[stall_cycle % 32];
  end

  // Run limit.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus generation and end of run.
  initial begin : main
    int unsigned sel;
    int unsigned len;
    int unsigned start_size;
    bit drain;

    // Directed part: empty takes, value extremes, order of pop and steal,
    // ignored batch marks, clear that keeps the run tally.
    enqueue_op(OP_POP, '1, 1'b1, 1'b0);
    enqueue_op(OP_STEAL, '0, 1'b0, 1'b0);
    enqueue_op(OP_PUSH, '0, 1'b0, 1'b0);
    enqueue_op(OP_PUSH, '1, 1'b0, 1'b0);
    enqueue_op(OP_PUSH, 32'hA5C3_0F96, 1'b1, 1'b0);
    enqueue_op(OP_POP, '0, 1'b0, 1'b0);
    enqueue_op(OP_STEAL, '1, 1'b1, 1'b0);
    enqueue_op(OP_STEAL, '0, 1'b0, 1'b0);
    enqueue_op(OP_STEAL, '0, 1'b0, 1'b0);
    enqueue_op(OP_PUSH, 32'h5A3C_F069, 1'b1, 1'b0);
    enqueue_op(OP_CLEAR, '1, 1'b1, 1'b0);
    enqueue_op(OP_POP, '0, 1'b0, 1'b0);
    enqueue_op(OP_PUSH, 32'h0000_0001, 1'b0, 1'b0);
    enqueue_op(OP_PUSH, 32'h8000_0000, 1'b0, 1'b0);
    enqueue_op(OP_CLEAR, '0, 1'b0, 1'b0);
    enqueue_op(OP_PUSH, 32'h1234_5678, 1'b1, 1'b0);
    enqueue_op(OP_STEAL, '0, 1'b0, 1'b0);
    enqueue_op(OP_CLEAR, '0, 1'b0, 1'b0);

    // Random part, built from sequences; the first one always waits for a drain.
    start_size = op_backlog.size();
    drain = 1'b1;
    while (op_backlog.size() < start_size + RANDOM_OPS) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        // Batch of pushes, usually closed by a batch mark.
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, DEPTH + 4)
                                           : $urandom_range(1, 10);
        for (int i = 0; i < len; i++)
          enqueue_op(OP_PUSH, rand_word(),
                     (i == len - 1) && ($urandom_range(0, 9) != 0), drain && i == 0);
      end else if (sel < 79) begin
        // Owner and thief draining, with stray batch marks.
        len = $urandom_range(1, 16);
        for (int i = 0; i < len; i++)
          enqueue_op($urandom_range(0, 1) ? OP_POP : OP_STEAL, rand_word(),
                     1'($urandom_range(0, 1)), drain && i == 0);
      end else if (sel < 83) begin
        // Push past full, so the tail of the run is refused.
        for (int i = 0; i < DEPTH + 2; i++)
          enqueue_op(OP_PUSH, rand_word(), i == DEPTH + 1, drain && i == 0);
      end else if (sel < 85) begin
        // Long run with a pop after each push, driving the tally to saturation.
        len = $urandom_range(DEPTH + 2, DEPTH + 20);
        for (int i = 0; i < len; i++) begin
          enqueue_op(OP_PUSH, rand_word(), 1'b0, drain && i == 0);
          enqueue_op(OP_POP, rand_word(), 1'b0, 1'b0);
        end
        enqueue_op(OP_PUSH, rand_word(), 1'b1, 1'b0);
      end else if (sel < 90) begin
        enqueue_op(OP_CLEAR, rand_word(), 1'($urandom_range(0, 1)), drain);
      end else begin
        enqueue_op(op_e'($urandom_range(0, 3)), rand_word(), 1'($urandom_range(0, 1)),
                   drain);
      end
      drain = ($urandom_range(0, 59) == 0);
    end

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every operation is taken and every result is back.
    while (op_backlog.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Checked %0d results: %0d pushes taken, %0d refused as full, %0d full hits.",
             n_results, n_push_taken, n_push_refused, n_full_hits);
    $display("Pops %0d, steals %0d, empty takes %0d, clears %0d, runs %0d (%0d saturated).",
             n_pop_taken, n_steal_taken, n_take_empty, n_clear, n_runs, n_runs_saturated);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ ring_deque_push_pop_steal.f @@
rtl/rdq_pkg.sv
rtl/rdq_ctrl.sv
rtl/rdq_dpath.sv
rtl/ring_deque_push_pop_steal.sv
tb/tb_ring_deque_push_pop_steal.sv
